@@ rtl/range_min_tree_with_shift_defines.svh @@
// Assertion macros for the range minimum tree.
// Used by the top level; depends on nothing else.
`ifndef RANGE_MIN_TREE_WITH_SHIFT_DEFINES_SVH
`define RANGE_MIN_TREE_WITH_SHIFT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define RMT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define RMT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/rmt_pkg.sv @@
// Shared constants and types for the range minimum tree.
// No dependencies.
package rmt_pkg;

    localparam int MAX_ENTRIES = 65536;
    localparam int NODE_COUNT  = 131072;
    localparam int POS_W       = 17;
    localparam int VAL_W       = 31;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int STACK_DEPTH = 17;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam logic [VAL_W-1:0] EMPTY_MIN = {VAL_W{1'b1}};

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_SHIFT = 2'd2;

    // APB byte address of entries_in_use
    localparam logic [1:0] ADDR_ENTRIES = 2'd0;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } span_t;

endpackage

@@ rtl/rmt_in_if.sv @@
// Input channel: one command word per handshake.
// Depends on rmt_pkg.
interface rmt_in_if;
    import rmt_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] query_left;
    logic [POS_W-1:0] query_right;
    logic             shift_last;

    modport source (output valid, command, position, value, query_left, query_right,
                    shift_last, input ready);
    modport sink   (input valid, command, position, value, query_left, query_right,
                    shift_last, output ready);
endinterface

@@ rtl/rmt_out_if.sv @@
// Output channel: one query result word per handshake.
// Depends on rmt_pkg.
interface rmt_out_if;
    import rmt_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] range_minimum;

    modport source (output valid, range_minimum, input ready);
    modport sink   (input valid, range_minimum, output ready);
endinterface

@@ rtl/range_min_tree_with_shift.sv @@
// Top level of the range minimum tree with cyclic shift.
// Depends on rmt_pkg, rmt_in_if, rmt_out_if and the assertion macro header.
`include "range_min_tree_with_shift_defines.svh"
// ---------------------------------------------------------------------------
// Usage
//  in_ch  : command words (point write, range query, shift step). One word is
//           taken at a time; ready is high only while the sequencer is idle.
//  out_ch : one result word per range query, held in an output register, so
//           the next command is taken while a result still waits.
//  APB    : register 0 is entries_in_use. Writing it restarts the clear pass.
// Operation (tree depth up to 16 for 65536 entries)
//  point write : walk down, write leaf, read sibling and write parent per
//                level on the way up (one memory port each).
//  shift step  : leaf read (none for an out-of-range last step), plus up to two point writes.
//  range query : visits the nodes in turn, reading each covered node.
//  All of it is set by the node memory walk (one read and one write port).
// Reset / configuration: the node memory is swept to zero, one node a cycle,
//  over all 131072 nodes, during which no command is taken.
// Stall: a finished query waits in state Q_OUT until the output register
//  frees; in_ch stays not ready meanwhile.
// ---------------------------------------------------------------------------
module range_min_tree_with_shift (
    input  logic                       clk,
    input  logic                       rst_n,
    rmt_in_if.sink                     in_ch,
    rmt_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rmt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DESC, S_LEAF_RD, S_UP_RD, S_UP_WB,
        S_Q_VISIT, S_Q_DRAIN, S_Q_OUT, S_SH_NEXT
    } state_t;

    typedef enum logic [1:0] {
        PH_POINT, PH_SH_READ, PH_SH_MOVE, PH_SH_CLOSE
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  n_reg, n_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    // tree walk
    logic [NODE_W-1:0] node_reg, node_next;
    logic [POS_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [POS_W-1:0]  tpos_reg, tpos_next;
    logic [VAL_W-1:0]  wval_reg, wval_next;
    logic              wmode_reg, wmode_next;
    // shift list
    logic [VAL_W-1:0]  first_reg, first_next;
    logic [POS_W-1:0]  prev_reg, prev_next;
    logic              active_reg, active_next;
    logic [POS_W-1:0]  shpos_reg, shpos_next;
    logic              shlast_reg, shlast_next;
    // query
    logic [POS_W-1:0]  ql_reg, ql_next, qh_reg, qh_next;
    logic [VAL_W-1:0]  ans_reg, ans_next;
    logic              pend_reg, pend_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    span_t             stack [STACK_DEPTH];
    logic              push_en;
    span_t             push_data;
    // output
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_data_reg, out_data_next;
    // node memory
    logic [VAL_W-1:0]  mem [NODE_COUNT];
    logic [VAL_W-1:0]  rdata_reg;
    logic              mem_we, mem_re;
    logic [NODE_W-1:0] mem_waddr, mem_raddr;
    logic [VAL_W-1:0]  mem_wdata;

    logic [POS_W-1:0]  n_eff, mid;
    logic              leaf, p_ok, cfg_wr, covered, go_l, go_r;
    logic [NODE_W-1:0] left_node, right_node;
    logic [VAL_W-1:0]  up_min;
    span_t             top;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ENTRIES);
    assign pready = 1'b1;
    assign prdata = {{(32-POS_W){1'b0}}, n_reg};
    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.range_minimum = out_data_reg;

    always_comb
    begin
        if (n_reg == '0)
            n_eff = POS_W'(1);
        else if (n_reg > POS_W'(MAX_ENTRIES))
            n_eff = POS_W'(MAX_ENTRIES);
        else
            n_eff = n_reg;
    end

    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign leaf       = (lo_reg >= hi_reg);
    assign left_node  = node_reg << 1;
    assign right_node = (node_reg << 1) | NODE_W'(1);
    assign p_ok       = (in_ch.position >= POS_W'(1)) && (in_ch.position <= n_eff);
    assign covered    = (ql_reg <= lo_reg) && (hi_reg <= qh_reg);
    assign go_l       = (ql_reg <= mid);
    assign go_r       = (mid < qh_reg);
    assign up_min     = (rdata_reg < wval_reg) ? rdata_reg : wval_reg;
    assign top        = stack[sp_reg[SP_W-1:0] - SP_W'(1)];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        tpos_next      = tpos_reg;
        wval_next      = wval_reg;
        wmode_next     = wmode_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        active_next    = active_reg;
        shpos_next     = shpos_reg;
        shlast_next    = shlast_reg;
        ql_next        = ql_reg;
        qh_next        = qh_reg;
        // fold in the node read issued last cycle
        ans_next       = (pend_reg && rdata_reg < ans_reg) ? rdata_reg : ans_reg;
        pend_next      = 1'b0;
        sp_next        = sp_reg;
        push_en        = 1'b0;
        push_data      = '{node: right_node, lo: mid + POS_W'(1), hi: hi_reg};
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = node_reg;
        mem_raddr      = node_reg;
        mem_wdata      = wval_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == NODE_W'(NODE_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    unique case (in_ch.command)
                        CMD_WRITE:
                        begin
                            if (p_ok)
                            begin
                                tpos_next  = in_ch.position;
                                wval_next  = in_ch.value;
                                wmode_next = 1'b1;
                                phase_next = PH_POINT;
                                node_next  = NODE_W'(1);
                                lo_next    = POS_W'(1);
                                hi_next    = n_eff;
                                state_next = S_DESC;
                            end
                        end
                        CMD_QUERY:
                        begin
                            ql_next    = in_ch.query_left;
                            qh_next    = in_ch.query_right;
                            ans_next   = EMPTY_MIN;
                            sp_next    = '0;
                            node_next  = NODE_W'(1);
                            lo_next    = POS_W'(1);
                            hi_next    = n_eff;
                            state_next = S_Q_VISIT;
                        end
                        CMD_SHIFT:
                        begin
                            shpos_next  = in_ch.position;
                            shlast_next = in_ch.shift_last;
                            node_next   = NODE_W'(1);
                            lo_next     = POS_W'(1);
                            hi_next     = n_eff;
                            if (p_ok)
                            begin
                                tpos_next  = in_ch.position;
                                wmode_next = 1'b0;
                                phase_next = PH_SH_READ;
                                state_next = S_DESC;
                            end
                            else if (in_ch.shift_last && active_reg)
                            begin
                                // out-of-range last step still closes the list
                                tpos_next  = prev_reg;
                                wval_next  = first_reg;
                                wmode_next = 1'b1;
                                phase_next = PH_SH_CLOSE;
                                state_next = S_DESC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DESC:
            begin
                if (leaf)
                begin
                    if (wmode_reg)
                    begin
                        mem_we     = 1'b1;
                        state_next = (node_reg == NODE_W'(1)) ? S_SH_NEXT : S_UP_RD;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_LEAF_RD;
                    end
                end
                else if (tpos_reg <= mid)
                begin
                    node_next = left_node;
                    hi_next   = mid;
                end
                else
                begin
                    node_next = right_node;
                    lo_next   = mid + POS_W'(1);
                end
            end
            S_UP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = node_reg ^ NODE_W'(1);
                state_next = S_UP_WB;
            end
            S_UP_WB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg >> 1;
                mem_wdata  = up_min;
                wval_next  = up_min;
                node_next  = node_reg >> 1;
                state_next = ((node_reg >> 1) == NODE_W'(1)) ? S_SH_NEXT : S_UP_RD;
            end
            S_LEAF_RD:
            begin
                node_next = NODE_W'(1);
                lo_next   = POS_W'(1);
                hi_next   = n_eff;
                prev_next = shpos_reg;
                if (active_reg)
                begin
                    // move this value to the previous list position
                    tpos_next  = prev_reg;
                    wval_next  = rdata_reg;
                    wmode_next = 1'b1;
                    phase_next = PH_SH_MOVE;
                    state_next = S_DESC;
                end
                else
                begin
                    first_next  = rdata_reg;
                    active_next = 1'b1;
                    if (shlast_reg)
                    begin
                        tpos_next  = shpos_reg;
                        wval_next  = rdata_reg;
                        wmode_next = 1'b1;
                        phase_next = PH_SH_CLOSE;
                        state_next = S_DESC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_SH_NEXT:
            begin
                node_next  = NODE_W'(1);
                lo_next    = POS_W'(1);
                hi_next    = n_eff;
                state_next = S_IDLE;
                case (phase_reg)
                    PH_SH_MOVE:
                    begin
                        if (shlast_reg)
                        begin
                            tpos_next  = prev_reg;
                            wval_next  = first_reg;
                            wmode_next = 1'b1;
                            phase_next = PH_SH_CLOSE;
                            state_next = S_DESC;
                        end
                    end
                    PH_SH_CLOSE:
                    begin
                        active_next = 1'b0;
                        first_next  = '0;
                        prev_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_Q_VISIT:
            begin
                if (covered || leaf || !(go_l || go_r))
                begin
                    if (covered)
                    begin
                        mem_re    = 1'b1;
                        pend_next = 1'b1;
                    end
                    if (sp_reg == '0)
                        state_next = S_Q_DRAIN;
                    else
                    begin
                        node_next = top.node;
                        lo_next   = top.lo;
                        hi_next   = top.hi;
                        sp_next   = sp_reg - SP_W'(1);
                    end
                end
                else if (go_l)
                begin
                    if (go_r)
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + SP_W'(1);
                    end
                    node_next = left_node;
                    hi_next   = mid;
                end
                else
                begin
                    node_next = right_node;
                    lo_next   = mid + POS_W'(1);
                end
            end
            S_Q_DRAIN:
                state_next = S_Q_OUT;
            S_Q_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ans_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cfg_wr)
        begin
            n_next      = pwdata[POS_W-1:0];
            clr_next    = '0;
            active_next = 1'b0;
            first_next  = '0;
            prev_next   = '0;
            state_next  = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= PH_POINT;
            n_reg         <= POS_W'(1);
            clr_reg       <= '0;
            active_reg    <= 1'b0;
            first_reg     <= '0;
            prev_reg      <= '0;
            pend_reg      <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            n_reg         <= n_next;
            clr_reg       <= clr_next;
            active_reg    <= active_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            pend_reg      <= pend_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        tpos_reg     <= tpos_next;
        wval_reg     <= wval_next;
        wmode_reg    <= wmode_next;
        shpos_reg    <= shpos_next;
        shlast_reg   <= shlast_next;
        ql_reg       <= ql_next;
        qh_reg       <= qh_next;
        ans_reg      <= ans_next;
        out_data_reg <= out_data_next;
        if (push_en)
            stack[sp_reg[SP_W-1:0]] <= push_data;
    end

    // node memory: one write and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    `RMT_ASSERT_ALWAYS(a_stack_bound, sp_reg <= SP_W'(STACK_DEPTH), "query stack overflow")
    `RMT_ASSERT_IMPLIES(a_out_from_query, $rose(out_valid_reg), $past(state_reg == S_Q_OUT), "result not from query")
    `RMT_ASSERT_IMPLIES(a_pend_in_query, pend_reg, state_reg == S_Q_VISIT || state_reg == S_Q_DRAIN || state_reg == S_CLEAR, "stray node read")

endmodule
